// ----- rtl/core/snot_pkg.sv -----
// ----------------------------------------------------------------------------
// Scheduled note-off table package
// Shared types and constants for the note-off slot chain and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package snot_pkg;

   // Default number of slots in the chain.
   localparam int SLOT_COUNT_DEFAULT = 8;

   // Most note-off results that one tick transaction may release.
   localparam int MAX_RESULTS = 8;

   // Width of the per-transaction release counter.
   localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);

   // Request function codes.
   typedef enum logic {
      FUNC_SCHEDULE = 1'b0,
      FUNC_TICK     = 1'b1
   } func_type;

   // Result kind codes.
   typedef enum logic [1:0] {
      KIND_OK   = 2'd0,
      KIND_FULL = 2'd1,
      KIND_DUE  = 2'd2
   } kind_type;

   // One request transaction.
   typedef struct packed {
      func_type    func;
      logic [31:0] now_ms;
      logic [6:0]  note_in;
      logic [6:0]  program_in;
      logic [30:0] hold_ms;
   } req_type;

   // One result transaction.
   typedef struct packed {
      kind_type   kind;
      logic [6:0] note_out;
      logic [6:0] program_out;
      logic       last;
   } rsp_type;

   // Token that walks the slot chain, one cell per cycle.
   typedef struct packed {
      logic                   active;
      func_type               func;
      logic [31:0]            now_ms;
      logic [6:0]             note;
      logic [6:0]             prog;
      logic [31:0]            deadline;
      logic                   placed;
      logic [COUNT_WIDTH-1:0] count;
   } token_type;

   // Release report from one cell; fields are zero when nothing is released.
   typedef struct packed {
      logic       hit;
      logic [6:0] note;
      logic [6:0] prog;
   } hit_type;

endpackage

`default_nettype wire

// ----- rtl/core/scheduled_note_off_table_top.sv -----
// ----------------------------------------------------------------------------
// Scheduled note-off table
// A chain of slot cells holding pending note-off events with deadlines.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction is taken when start is high and busy is low. A
// schedule request stores note, program and now_ms + hold_ms in the lowest
// free slot and answers with one result, kind ok or full, with last set.
// A tick request releases every occupied slot whose deadline has been
// reached (now minus deadline, as signed 32 bits, not negative), at most
// MAX_RESULTS per tick, and answers with one due result per released slot
// in slot order, the final one marked last. A tick with nothing due gives
// no result.
// Each result is shown for one cycle with rsp_strobe high; the receiver
// cannot stall, so results are never held back.
// Timing: a token walks the chain one cell per cycle, so busy stays high
// while the token is in the head register and the cells, and falls as it
// leaves the last cell; a new request is taken only once busy is low. Each
// due result is held back until the next release or the token's exit, one
// per cycle at most; the final result appears in the cycle in which busy falls.
// Reset clears all slots to free and drops any transaction in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_note_off_table_top #(
   parameter int SLOT_COUNT = snot_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  snot_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output snot_pkg::rsp_type  rsp_data
);

   snot_pkg::token_type tok [SLOT_COUNT+1];
   snot_pkg::hit_type   hits [SLOT_COUNT];
   snot_pkg::hit_type   hit_any;

   logic                busy_ff;
   logic                busy_in;
   snot_pkg::token_type head_ff;
   snot_pkg::token_type head_in;
   logic                pend_valid_ff;
   logic                pend_valid_in;
   snot_pkg::hit_type   pend_ff;
   snot_pkg::hit_type   pend_in;
   logic                rsp_strobe_ff;
   logic                rsp_strobe_in;
   snot_pkg::rsp_type   rsp_ff;
   snot_pkg::rsp_type   rsp_in;
   logic                accept;
   logic                token_exit;

   // The slot chain.
   assign tok[0] = head_ff;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      snot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .token_in  (tok[i]),
         .token_out (tok[i+1]),
         .hit_out   (hits[i])
      );
   end

   // Only the cell holding the token can report, so the reports are ORed.
   always_comb begin
      hit_any = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit_any = hit_any | hits[i];
      end
   end

   assign accept     = start && !busy_ff;
   assign token_exit = tok[SLOT_COUNT].active;

   // Sequencing: launch the token, hold one release back to mark the last.
   always_comb begin
      busy_in       = busy_ff;
      head_in       = head_ff;
      head_in.active = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (accept) begin
         busy_in          = 1'b1;
         head_in.active   = 1'b1;
         head_in.func     = req_data.func;
         head_in.now_ms   = req_data.now_ms;
         head_in.note     = req_data.note_in;
         head_in.prog     = req_data.program_in;
         head_in.deadline = req_data.now_ms + {1'b0, req_data.hold_ms};
         head_in.placed   = 1'b0;
         head_in.count    = '0;
      end

      // A new release pushes out the one held before it.
      if (hit_any.hit) begin
         if (pend_valid_ff) begin
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = snot_pkg::KIND_DUE;
            rsp_in.note_out    = pend_ff.note;
            rsp_in.program_out = pend_ff.prog;
            rsp_in.last        = 1'b0;
         end
         pend_in       = hit_any;
         pend_valid_in = 1'b1;
      end

      // Token has left the chain: close the transaction.
      if (token_exit) begin
         busy_in = 1'b0;
         if (tok[SLOT_COUNT].func == snot_pkg::FUNC_SCHEDULE) begin
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = tok[SLOT_COUNT].placed ? snot_pkg::KIND_OK
                                                        : snot_pkg::KIND_FULL;
            rsp_in.note_out    = 7'd0;
            rsp_in.program_out = 7'd0;
            rsp_in.last        = 1'b1;
         end else if (pend_valid_ff) begin
            rsp_strobe_in      = 1'b1;
            rsp_in.kind        = snot_pkg::KIND_DUE;
            rsp_in.note_out    = pend_ff.note;
            rsp_in.program_out = pend_ff.prog;
            rsp_in.last        = 1'b1;
            pend_valid_in      = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         head_ff.active <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         head_ff       <= head_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/snot_cell.sv -----
// ----------------------------------------------------------------------------
// Note-off slot cell
// Holds one pending note-off event and hands the walking token to the next
// cell. Takes a scheduled event when free, releases it on a due tick.
// ----------------------------------------------------------------------------
`default_nettype none

module snot_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  snot_pkg::token_type  token_in,
   output snot_pkg::token_type  token_out,
   output snot_pkg::hit_type    hit_out
);

   logic                valid_ff;
   logic                valid_in;
   logic [6:0]          note_ff;
   logic [6:0]          program_ff;
   logic [31:0]         deadline_ff;
   snot_pkg::token_type token_ff;
   snot_pkg::token_type token_in_mod;
   logic [31:0]         diff;
   logic                store;
   logic                due;

   // Decide whether this cell takes the event or releases its own.
   always_comb begin
      diff  = token_in.now_ms - deadline_ff;
      store = token_in.active && (token_in.func == snot_pkg::FUNC_SCHEDULE) &&
              !valid_ff && !token_in.placed;
      due   = token_in.active && (token_in.func == snot_pkg::FUNC_TICK) &&
              valid_ff && !diff[31] &&
              (token_in.count < snot_pkg::COUNT_WIDTH'(snot_pkg::MAX_RESULTS));

      valid_in = valid_ff;
      if (store) begin
         valid_in = 1'b1;
      end else if (due) begin
         valid_in = 1'b0;
      end

      token_in_mod        = token_in;
      token_in_mod.placed = token_in.placed | store;
      if (due) begin
         token_in_mod.count = token_in.count + snot_pkg::COUNT_WIDTH'(1);
      end

      hit_out.hit  = due;
      hit_out.note = due ? note_ff : 7'd0;
      hit_out.prog = due ? program_ff : 7'd0;
   end

   // Control state: slot occupancy and token presence.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         token_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         token_ff <= token_in_mod;
      end
   end

   // Slot payload, written only when an event is stored here.
   always_ff @(posedge clock) begin
      if (store) begin
         note_ff     <= token_in.note;
         program_ff  <= token_in.prog;
         deadline_ff <= token_in.deadline;
      end
   end

   assign token_out = token_ff;

endmodule

`default_nettype wire

// ----- rtl/core/snot_checker.sv -----
// ----------------------------------------------------------------------------
// Scheduled note-off table checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module snot_checker (
   input wire               clock,
   input wire               reset,
   input wire               start,
   input wire               busy,
   input snot_pkg::req_type req_data,
   input wire               rsp_strobe,
   input snot_pkg::rsp_type rsp_data
);

   // An accepted transaction keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted request");

   // A result only follows a cycle in which a transaction was in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a transaction in flight");

   // The final result of a transaction comes as the block goes idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy)
      else $error("last result while still busy");

   // Schedule answers are marked last and carry no note or program.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.kind != snot_pkg::KIND_DUE) |->
         rsp_data.last && (rsp_data.note_out == 7'd0) &&
         (rsp_data.program_out == 7'd0))
      else $error("malformed schedule answer");

endmodule

bind scheduled_note_off_table_top snot_checker u_snot_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
